/* rtl/obfv_pkg.sv */
`default_nettype none

package obfv_pkg;

  localparam int COMP_WIDTH = 16;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] in_x;
    logic signed [COMP_WIDTH-1:0] in_y;
    logic signed [COMP_WIDTH-1:0] in_z;
  } vec_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] second_x;
    logic signed [COMP_WIDTH-1:0] second_y;
    logic signed [COMP_WIDTH-1:0] second_z;
    logic signed [COMP_WIDTH-1:0] third_x;
    logic signed [COMP_WIDTH-1:0] third_y;
    logic signed [COMP_WIDTH-1:0] third_z;
    logic                         degenerate;
    logic                         saturated;
  } basis_t;

  // per-item control carried alongside the datapath
  typedef struct packed {
    logic                         branch_x;
    logic                         degen;
    logic                         neg_a;
    logic                         neg_b;
    logic signed [COMP_WIDTH-1:0] x;
    logic signed [COMP_WIDTH-1:0] y;
    logic signed [COMP_WIDTH-1:0] z;
  } side_t;

endpackage

`default_nettype wire

/* rtl/obfv_root_step.sv */
`default_nettype none

module obfv_root_step #(
  parameter int FRAC_BITS = 14,
  parameter int BIT       = 0
) (
  input  wire logic                                          clk,
  input  wire logic                                          ld,
  input  wire logic [2*obfv_pkg::COMP_WIDTH-1:0]             s_in,
  input  wire logic [2*obfv_pkg::COMP_WIDTH-2:0]             sq_in,
  input  wire logic [2*obfv_pkg::COMP_WIDTH+2*FRAC_BITS:0]   p_in,
  input  wire logic [2*obfv_pkg::COMP_WIDTH+FRAC_BITS-1:0]   q_in,
  input  wire logic [FRAC_BITS:0]                            m_in,
  output logic      [2*obfv_pkg::COMP_WIDTH-1:0]             s_out,
  output logic      [2*obfv_pkg::COMP_WIDTH-2:0]             sq_out,
  output logic      [2*obfv_pkg::COMP_WIDTH+2*FRAC_BITS:0]   p_out,
  output logic      [2*obfv_pkg::COMP_WIDTH+FRAC_BITS-1:0]   q_out,
  output logic      [FRAC_BITS:0]                            m_out
);
  import obfv_pkg::*;

  localparam int PW = 2*COMP_WIDTH + 2*FRAC_BITS + 1;
  localparam int QW = 2*COMP_WIDTH + FRAC_BITS;

  logic [PW-1:0] cand;
  logic [PW-1:0] lim;
  logic          take;

  // (m + 2^b)^2 * s = m^2*s + 2^(b+1)*m*s + 2^(2b)*s
  always_comb begin
    cand = p_in + (PW'(q_in) << (BIT + 1)) + (PW'(s_in) << (2*BIT));
    lim  = PW'(sq_in) << (2*FRAC_BITS);
    take = (cand <= lim);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      s_out  <= s_in;
      sq_out <= sq_in;
      if (take) begin
        p_out <= cand;
        q_out <= q_in + (QW'(s_in) << BIT);
        m_out <= m_in | ((FRAC_BITS+1)'(1) << BIT);
      end else begin
        p_out <= p_in;
        q_out <= q_in;
        m_out <= m_in;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/orthonormal_basis_from_vector_core.sv */
`default_nettype none

// channel  | dir | handshake                | payload
// vec      | in  | vec_valid / vec_stall     | obfv_pkg::vec_t   (in_x, in_y, in_z)
// basis    | out | basis_valid / basis_stall | obfv_pkg::basis_t (axes and flags)
//
// one beat accepted per cycle while vec_stall is low; every beat gives exactly one result beat
// stages in order: abs/select, squares, sum, one normalising step
// per result bit (FRAC_BITS+1 stages), axis sign/clamp, cross products, round
// each full stage holds while the next one is full and stalled; bubbles close up
// rst clears the valid bits only

module orthonormal_basis_from_vector_core #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             vec_valid,
  output logic                  vec_stall,
  input  wire obfv_pkg::vec_t   vec,
  output logic                  basis_valid,
  input  wire logic             basis_stall,
  output obfv_pkg::basis_t      basis
);
  import obfv_pkg::*;

  localparam int W    = COMP_WIDTH;
  localparam int PW   = 2*W + 2*FRAC_BITS + 1;
  localparam int QW   = 2*W + FRAC_BITS;
  localparam int LW   = (FRAC_BITS + 2 > W) ? FRAC_BITS + 2 : W;
  localparam int DW   = 2*W + 1;
  localparam int TW   = 2*W + 2;
  localparam int ST_W = FRAC_BITS + 4;
  localparam int ST_P = FRAC_BITS + 5;
  localparam int ST_O = FRAC_BITS + 6;
  localparam int N    = FRAC_BITS + 7;

  localparam logic signed [LW-1:0] AX_HI = $signed(LW'({1'b0, {(W-1){1'b1}}}));
  localparam logic signed [LW-1:0] AX_LO = -AX_HI - LW'(1);
  localparam logic signed [TW-1:0] TH_HI = $signed(TW'({1'b0, {(W-1){1'b1}}}));
  localparam logic signed [TW-1:0] TH_LO = -TH_HI - TW'(1);

  // stage valids and the ready chain
  logic [N-1:0] vld;
  logic [N:0]   rdy;
  logic [N-1:0] vld_in;

  assign rdy[N]      = !basis_stall;
  assign vld_in      = {vld[N-2:0], vec_valid};
  assign vec_stall   = !rdy[0];
  assign basis_valid = vld[N-1];

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_rdy
      assign rdy[gi] = !vld[gi] || rdy[gi+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // abs and branch select
  logic [W-1:0] ax, ay, az;
  logic         bx;
  side_t        side1_next;

  always_comb begin
    ax = vec.in_x[W-1] ? W'(-vec.in_x) : W'(vec.in_x);
    ay = vec.in_y[W-1] ? W'(-vec.in_y) : W'(vec.in_y);
    az = vec.in_z[W-1] ? W'(-vec.in_z) : W'(vec.in_z);
    bx = ax > ay;
    side1_next.branch_x = bx;
    side1_next.degen    = 1'b0;
    side1_next.neg_a    = bx ? (!vec.in_z[W-1] && vec.in_z != '0) : vec.in_z[W-1];
    side1_next.neg_b    = bx ? vec.in_x[W-1] : (!vec.in_y[W-1] && vec.in_y != '0);
    side1_next.x        = vec.in_x;
    side1_next.y        = vec.in_y;
    side1_next.z        = vec.in_z;
  end

  side_t        side1;
  logic [W-1:0] aa1, ab1;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side1 <= side1_next;
      aa1   <= az;
      ab1   <= bx ? ax : ay;
    end
  end

  // squares
  side_t          side2;
  logic [2*W-2:0] sqa2, sqb2;
  logic [2*W-1:0] sqa_full, sqb_full;

  assign sqa_full = aa1 * aa1;
  assign sqb_full = ab1 * ab1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      side2 <= side1;
      sqa2  <= sqa_full[2*W-2:0];
      sqb2  <= sqb_full[2*W-2:0];
    end
  end

  // sum of squares
  side_t          side3;
  side_t          side3_next;
  logic [2*W-2:0] sqa3, sqb3;
  logic [2*W-1:0] s3;

  always_comb begin
    side3_next       = side2;
    side3_next.degen = (sqa2 == '0) && (sqb2 == '0);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      side3 <= side3_next;
      sqa3  <= sqa2;
      sqb3  <= sqb2;
      s3    <= {1'b0, sqa2} + {1'b0, sqb2};
    end
  end

  // normalising steps, most significant bit first
  side_t          side_r [0:FRAC_BITS+1];
  logic [2*W-1:0] s_a    [0:FRAC_BITS+1];
  logic [2*W-1:0] s_b    [0:FRAC_BITS+1];
  logic [2*W-2:0] sq_a   [0:FRAC_BITS+1];
  logic [2*W-2:0] sq_b   [0:FRAC_BITS+1];
  logic [PW-1:0]  p_a    [0:FRAC_BITS+1];
  logic [PW-1:0]  p_b    [0:FRAC_BITS+1];
  logic [QW-1:0]  q_a    [0:FRAC_BITS+1];
  logic [QW-1:0]  q_b    [0:FRAC_BITS+1];
  logic [FRAC_BITS:0] m_a [0:FRAC_BITS+1];
  logic [FRAC_BITS:0] m_b [0:FRAC_BITS+1];

  assign side_r[0] = side3;
  assign s_a[0]    = s3;
  assign s_b[0]    = s3;
  assign sq_a[0]   = sqa3;
  assign sq_b[0]   = sqb3;
  assign p_a[0]    = '0;
  assign p_b[0]    = '0;
  assign q_a[0]    = '0;
  assign q_b[0]    = '0;
  assign m_a[0]    = '0;
  assign m_b[0]    = '0;

  generate
    for (gi = 0; gi <= FRAC_BITS; gi++) begin : g_root
      always_ff @(posedge clk) begin
        if (rdy[3+gi]) begin
          side_r[gi+1] <= side_r[gi];
        end
      end

      obfv_root_step #(
        .FRAC_BITS (FRAC_BITS),
        .BIT       (FRAC_BITS - gi)
      ) u_step_a (
        .clk    (clk),
        .ld     (rdy[3+gi]),
        .s_in   (s_a[gi]),
        .sq_in  (sq_a[gi]),
        .p_in   (p_a[gi]),
        .q_in   (q_a[gi]),
        .m_in   (m_a[gi]),
        .s_out  (s_a[gi+1]),
        .sq_out (sq_a[gi+1]),
        .p_out  (p_a[gi+1]),
        .q_out  (q_a[gi+1]),
        .m_out  (m_a[gi+1])
      );

      obfv_root_step #(
        .FRAC_BITS (FRAC_BITS),
        .BIT       (FRAC_BITS - gi)
      ) u_step_b (
        .clk    (clk),
        .ld     (rdy[3+gi]),
        .s_in   (s_b[gi]),
        .sq_in  (sq_b[gi]),
        .p_in   (p_b[gi]),
        .q_in   (q_b[gi]),
        .m_in   (m_b[gi]),
        .s_out  (s_b[gi+1]),
        .sq_out (sq_b[gi+1]),
        .p_out  (p_b[gi+1]),
        .q_out  (q_b[gi+1]),
        .m_out  (m_b[gi+1])
      );
    end
  endgenerate

  // signed, clamped second axis
  function automatic logic signed [W-1:0] to_axis(input logic [FRAC_BITS:0] mag,
                                                   input logic neg);
    logic signed [LW-1:0] v;
    v = neg ? -$signed(LW'(mag)) : $signed(LW'(mag));
    if (v > AX_HI) begin
      v = AX_HI;
    end else if (v < AX_LO) begin
      v = AX_LO;
    end
    return v[W-1:0];
  endfunction

  side_t               side_w;
  logic signed [W-1:0] w0, w1, w2;
  logic signed [W-1:0] wa, wb;
  side_t               side_l;

  assign side_l = side_r[FRAC_BITS+1];
  assign wa     = to_axis(m_a[FRAC_BITS+1], side_l.neg_a);
  assign wb     = to_axis(m_b[FRAC_BITS+1], side_l.neg_b);

  always_ff @(posedge clk) begin
    if (rdy[ST_W]) begin
      side_w <= side_l;
      if (side_l.degen) begin
        w0 <= '0;
        w1 <= '0;
        w2 <= '0;
      end else if (side_l.branch_x) begin
        w0 <= wa;
        w1 <= '0;
        w2 <= wb;
      end else begin
        w0 <= '0;
        w1 <= wa;
        w2 <= wb;
      end
    end
  end

  // cross product terms
  side_t                 side_p;
  logic signed [W-1:0]   sw0, sw1, sw2;
  logic signed [2*W-1:0] yw2, zw1, zw0, xw2, xw1, yw0;

  always_ff @(posedge clk) begin
    if (rdy[ST_P]) begin
      side_p <= side_w;
      sw0    <= w0;
      sw1    <= w1;
      sw2    <= w2;
      yw2    <= side_w.y * w2;
      zw1    <= side_w.z * w1;
      zw0    <= side_w.z * w0;
      xw2    <= side_w.x * w2;
      xw1    <= side_w.x * w1;
      yw0    <= side_w.y * w0;
    end
  end

  // difference, round half up, clamp; top bit flags a clamp
  function automatic logic [W:0] round_clamp(input logic signed [2*W-1:0] pa,
                                             input logic signed [2*W-1:0] pb);
    logic signed [DW-1:0] d;
    logic signed [TW-1:0] t;
    logic signed [TW-1:0] r;
    logic                 hit;
    d   = DW'(pa) - DW'(pb);
    t   = TW'(d) + (TW'(1) << (FRAC_BITS - 1));
    r   = t >>> FRAC_BITS;
    hit = 1'b0;
    if (r > TH_HI) begin
      r   = TH_HI;
      hit = 1'b1;
    end else if (r < TH_LO) begin
      r   = TH_LO;
      hit = 1'b1;
    end
    return {hit, r[W-1:0]};
  endfunction

  logic [W:0] t0, t1, t2;

  assign t0 = round_clamp(yw2, zw1);
  assign t1 = round_clamp(zw0, xw2);
  assign t2 = round_clamp(xw1, yw0);

  always_ff @(posedge clk) begin
    if (rdy[ST_O]) begin
      basis.second_x   <= sw0;
      basis.second_y   <= sw1;
      basis.second_z   <= sw2;
      basis.third_x    <= t0[W-1:0];
      basis.third_y    <= t1[W-1:0];
      basis.third_z    <= t2[W-1:0];
      basis.degenerate <= side_p.degen;
      basis.saturated  <= t0[W] | t1[W] | t2[W];
    end
  end

endmodule

`default_nettype wire
